@@ rtl/bilinear_image_scaler_assert.svh @@
// assertion macros for the bilinear image scaler
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bis_pkg.sv @@
// shared constants for the bilinear image scaler
// no dependencies
package bis_pkg;
    localparam int C_SZW     = 15;   // internal width of sizes and destination counters
    localparam int C_POSW    = 14;   // width of destination coordinates on the output
    localparam int C_PIXW    = 8;    // grey level width
    localparam int C_CFG_IDXW = 2;   // register index width
    localparam int C_DST_LIMIT = 16384;
    localparam int C_OUT_TDATAW = 40;

    typedef enum logic [C_CFG_IDXW-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;
endpackage

@@ rtl/bis_coord_div.sv @@
// source tap and weight of one destination coordinate
// restoring divider, one quotient bit per cycle; uses bis_pkg
module bis_coord_div #(
    parameter int WEIGHT_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bis_pkg::C_SZW-1:0]   i_d,
    input  logic [bis_pkg::C_SZW-1:0]   i_s,
    input  logic [bis_pkg::C_SZW-1:0]   i_n,
    output logic                        o_done,
    output logic [bis_pkg::C_SZW-1:0]   o_tap,
    output logic [WEIGHT_BITS-1:0]      o_frac
);
    import bis_pkg::*;

    localparam int PRODW = 2 * C_SZW + 1;
    localparam int UW    = PRODW + WEIGHT_BITS;
    localparam int CNTW  = $clog2(UW + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_div_state;

    t_div_state              r_state;
    logic [C_SZW-1:0]        r_d, r_s, r_n;
    logic                    r_zero;
    logic [UW-1:0]           r_dvd;
    logic [C_SZW:0]          r_rem;
    logic [C_SZW:0]          r_den;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_done;
    logic [C_SZW-1:0]        r_tap;
    logic [WEIGHT_BITS-1:0]  r_frac;

    logic [PRODW-1:0]        w_prod;
    logic signed [PRODW:0]   w_num;
    logic [C_SZW+1:0]        w_trial;
    logic                    w_qbit;
    logic [PRODW-1:0]        w_int;
    logic [WEIGHT_BITS-1:0]  w_f;
    logic [PRODW-1:0]        w_sm1;

    always_comb begin
        w_prod  = PRODW'({r_d, 1'b1}) * PRODW'(r_s);
        w_num   = $signed({1'b0, w_prod}) - $signed((PRODW+1)'(r_n));
        w_trial = {r_rem, r_dvd[UW-1]};
        w_qbit  = (w_trial >= (C_SZW+2)'(r_den));
        w_int   = r_dvd[UW-1:WEIGHT_BITS];
        w_f     = r_dvd[WEIGHT_BITS-1:0];
        w_sm1   = PRODW'(r_s) - PRODW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_d     <= i_d;
                        r_s     <= i_s;
                        r_n     <= i_n;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_zero  <= (w_num <= 0);
                    r_dvd   <= {w_num[PRODW-1:0], {WEIGHT_BITS{1'b0}}};
                    r_den   <= {r_n, 1'b0};
                    r_rem   <= '0;
                    r_cnt   <= CNTW'(UW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= w_qbit ? (C_SZW+1)'(w_trial - (C_SZW+2)'(r_den))
                                      : w_trial[C_SZW:0];
                    r_dvd   <= {r_dvd[UW-2:0], w_qbit};
                    r_cnt   <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_zero) begin
                        r_tap  <= '0;
                        r_frac <= '0;
                    end else if (w_int >= w_sm1) begin
                        r_tap  <= r_s - C_SZW'(1);
                        r_frac <= '0;
                    end else if (w_f == '0) begin
                        r_tap  <= w_int[C_SZW-1:0];
                        r_frac <= '0;
                    end else begin
                        r_tap  <= w_int[C_SZW-1:0] + C_SZW'(1);
                        r_frac <= w_f;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_tap  = r_tap;
    assign o_frac = r_frac;
endmodule

@@ rtl/bis_interp.sv @@
// two-stage bilinear blend of four taps with rounding and clamp
// uses bis_pkg
module bis_interp #(
    parameter int WEIGHT_BITS = 8
) (
    input  logic                         i_clk,
    input  logic [bis_pkg::C_PIXW-1:0]   i_pix,
    input  logic [bis_pkg::C_PIXW-1:0]   i_up,
    input  logic [bis_pkg::C_PIXW-1:0]   i_left_up,
    input  logic [bis_pkg::C_PIXW-1:0]   i_left_low,
    input  logic [WEIGHT_BITS-1:0]       i_fx,
    input  logic [WEIGHT_BITS-1:0]       i_fy,
    output logic [bis_pkg::C_PIXW-1:0]   o_value
);
    import bis_pkg::*;

    localparam int WW   = WEIGHT_BITS + 1;
    localparam int ROWW = C_PIXW + WW + 1;
    localparam int SUMW = ROWW + WW + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_BITS;

    logic [C_PIXW-1:0] w_tl, w_tr, w_bl, w_br;
    logic [WW-1:0]     w_fx, w_fy;
    logic [ROWW-1:0]   r_top, r_bot;
    logic [WW-1:0]     r_fy;
    logic [SUMW-1:0]   w_sum, w_val;
    logic [C_PIXW-1:0] r_value;

    always_comb begin
        w_fx = WW'(i_fx);
        w_fy = WW'(r_fy);
        w_br = i_pix;
        w_bl = (i_fx != '0) ? i_left_low : i_pix;
        w_tr = (i_fy != '0) ? i_up : w_br;
        w_tl = (i_fy != '0) ? ((i_fx != '0) ? i_left_up : i_up) : w_bl;
        w_sum = SUMW'(r_top) * SUMW'(ONE - w_fy) + SUMW'(r_bot) * SUMW'(w_fy)
              + (SUMW'(1) << (2 * WEIGHT_BITS - 1));
        w_val = w_sum >> (2 * WEIGHT_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_top   <= ROWW'(ONE - w_fx) * ROWW'(w_tl) + ROWW'(w_fx) * ROWW'(w_tr);
        r_bot   <= ROWW'(ONE - w_fx) * ROWW'(w_bl) + ROWW'(w_fx) * ROWW'(w_br);
        r_fy    <= WW'(i_fy);
        r_value <= (w_val > SUMW'(255)) ? C_PIXW'(255) : w_val[C_PIXW-1:0];
    end

    assign o_value = r_value;
endmodule

@@ rtl/bilinear_image_scaler.sv @@
// bilinear image scaler: one source pixel per input beat, 0..36 result beats per input.
// every coordinate lookup runs on one shared divider, bis_coord_div.
// per input: a column scan and a row scan, each with one lookup per destination column/row
// completed plus one that ends the scan unless it runs off the frame edge, then one lookup
// per result row and one per result, each result waiting for a free output; the input is not ready meanwhile.
// synchronous active-low reset: sizes 1x1->1x1, counters and neighbors zero;
// the line store is not cleared and holds garbage until the first line is written.
module bilinear_image_scaler #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int WEIGHT_BITS = 8,
    parameter int MAX_UPSCALE = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bis_pkg::C_OUT_TDATAW-1:0] m_tdata,  // [7:0] out_pixel, [21:8] out_col,
                                                       // [35:22] out_row, [39:36] zero
    output logic                            m_tlast,   // last_of_run
    output logic                            m_tuser,   // frame_done
    input  logic                            i_cfg_we,
    input  logic [bis_pkg::C_CFG_IDXW-1:0]  i_cfg_idx,
    input  logic [14:0]                     i_cfg_data
);
    import bis_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = C_SZW + 3;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CSCAN = 13'b0000000000010,
        S_CWAIT = 13'b0000000000100,
        S_RSCAN = 13'b0000000001000,
        S_RWAIT = 13'b0000000010000,
        S_FYS   = 13'b0000000100000,
        S_FYW   = 13'b0000001000000,
        S_FXS   = 13'b0000010000000,
        S_FXW   = 13'b0000100000000,
        S_AR1   = 13'b0001000000000,
        S_AR2   = 13'b0010000000000,
        S_EMIT  = 13'b0100000000000,
        S_UPD   = 13'b1000000000000
    } t_state;

    t_state                 r_state;
    logic [12:0]            r_src_w, r_src_h;
    logic [14:0]            r_dst_w, r_dst_h;
    logic [CW-1:0]          r_scol, r_c;
    logic [RW-1:0]          r_srow, r_r;
    logic [C_SZW-1:0]       r_pcol, r_prow, r_d, r_e, r_d1, r_e1;
    logic [C_PIXW-1:0]      r_p, r_up, r_lu, r_ll;
    logic [WEIGHT_BITS-1:0] r_fx, r_fy;
    logic [C_PIXW-1:0]      r_line [MAX_WIDTH];
    logic                   r_mv;
    logic [C_OUT_TDATAW-1:0] r_mdata;
    logic                   r_mlast, r_muser;

    logic [C_SZW-1:0]       w_sw, w_sh, w_dw, w_dh;
    logic [LW-1:0]          w_lim_w, w_lim_h;
    logic                   w_accept;
    logic [CW-1:0]          w_c;
    logic                   w_div_start, w_row_axis, w_div_done;
    logic [C_SZW-1:0]       w_div_d, w_div_s, w_div_n, w_tap;
    logic [WEIGHT_BITS-1:0] w_frac;
    logic [C_PIXW-1:0]      w_value;
    logic                   w_out_free;

    always_comb begin
        w_sw = (r_src_w == '0) ? C_SZW'(1) :
               (C_SZW'(r_src_w) > C_SZW'(MAX_WIDTH)) ? C_SZW'(MAX_WIDTH) : C_SZW'(r_src_w);
        w_sh = (r_src_h == '0) ? C_SZW'(1) :
               (C_SZW'(r_src_h) > C_SZW'(MAX_HEIGHT)) ? C_SZW'(MAX_HEIGHT) : C_SZW'(r_src_h);
        w_lim_w = LW'(w_sw) * LW'(MAX_UPSCALE);
        w_lim_h = LW'(w_sh) * LW'(MAX_UPSCALE);
        if (w_lim_w > LW'(C_DST_LIMIT)) w_lim_w = LW'(C_DST_LIMIT);
        if (w_lim_h > LW'(C_DST_LIMIT)) w_lim_h = LW'(C_DST_LIMIT);
        w_dw = (r_dst_w == '0) ? C_SZW'(1) :
               (LW'(r_dst_w) > w_lim_w) ? w_lim_w[C_SZW-1:0] : r_dst_w;
        w_dh = (r_dst_h == '0) ? C_SZW'(1) :
               (LW'(r_dst_h) > w_lim_h) ? w_lim_h[C_SZW-1:0] : r_dst_h;

        w_accept   = s_tvalid && s_tready;
        w_c        = (C_SZW'(r_scol) >= w_sw) ? '0 : r_scol;
        w_row_axis = (r_state == S_RSCAN) || (r_state == S_FYS);
        w_div_start = ((r_state == S_CSCAN) && (r_d < w_dw))
                   || ((r_state == S_RSCAN) && (r_e < w_dh))
                   || (r_state == S_FYS) || (r_state == S_FXS);
        w_div_d    = w_row_axis ? r_e : r_d;
        w_div_s    = w_row_axis ? w_sh : w_sw;
        w_div_n    = w_row_axis ? w_dh : w_dw;
        w_out_free = !r_mv || m_tready;
    end

    bis_coord_div #(.WEIGHT_BITS(WEIGHT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_d     (w_div_d),
        .i_s     (w_div_s),
        .i_n     (w_div_n),
        .o_done  (w_div_done),
        .o_tap   (w_tap),
        .o_frac  (w_frac)
    );

    bis_interp #(.WEIGHT_BITS(WEIGHT_BITS)) u_interp (
        .i_clk      (i_clk),
        .i_pix      (r_p),
        .i_up       (r_up),
        .i_left_up  (r_lu),
        .i_left_low (r_ll),
        .i_fx       (r_fx),
        .i_fy       (r_fy),
        .o_value    (w_value)
    );

    // line store: registered read on accept, write at the end of the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_up <= r_line[w_c];
        end
        if (r_state == S_UPD) begin
            r_line[r_c] <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src_w <= 13'd1;
            r_src_h <= 13'd1;
            r_dst_w <= 15'd1;
            r_dst_h <= 15'd1;
            r_scol  <= '0;
            r_srow  <= '0;
            r_pcol  <= '0;
            r_prow  <= '0;
            r_lu    <= '0;
            r_ll    <= '0;
            r_mv    <= 1'b0;
        end else begin
            if (m_tready && (r_state != S_EMIT)) begin
                r_mv <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[12:0];
                    CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[12:0];
                    CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                    CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                    default: ;
                endcase
                r_scol <= '0;
                r_srow <= '0;
                r_pcol <= '0;
                r_prow <= '0;
                r_lu   <= '0;
                r_ll   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_p     <= s_tdata;
                        r_c     <= w_c;
                        r_r     <= (C_SZW'(r_srow) >= w_sh) ? '0 : r_srow;
                        r_d     <= r_pcol;
                        r_e     <= r_prow;
                        r_state <= S_CSCAN;
                    end
                end
                S_CSCAN: begin
                    if (r_d >= w_dw) begin
                        r_d1    <= r_d;
                        r_state <= S_RSCAN;
                    end else begin
                        r_state <= S_CWAIT;
                    end
                end
                S_CWAIT: begin
                    if (w_div_done) begin
                        if (w_tap == C_SZW'(r_c)) begin
                            r_d     <= r_d + C_SZW'(1);
                            r_state <= S_CSCAN;
                        end else begin
                            r_d1    <= r_d;
                            r_state <= S_RSCAN;
                        end
                    end
                end
                S_RSCAN: begin
                    if (r_e >= w_dh) begin
                        r_e1    <= r_e;
                        r_e     <= r_prow;
                        r_state <= (r_prow == r_e || r_pcol == r_d1) ? S_UPD : S_FYS;
                    end else begin
                        r_state <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    if (w_div_done) begin
                        if (w_tap == C_SZW'(r_r)) begin
                            r_e     <= r_e + C_SZW'(1);
                            r_state <= S_RSCAN;
                        end else begin
                            r_e1    <= r_e;
                            r_e     <= r_prow;
                            r_state <= (r_prow == r_e || r_pcol == r_d1) ? S_UPD : S_FYS;
                        end
                    end
                end
                S_FYS: r_state <= S_FYW;
                S_FYW: begin
                    if (w_div_done) begin
                        r_fy    <= w_frac;
                        r_d     <= r_pcol;
                        r_state <= S_FXS;
                    end
                end
                S_FXS: r_state <= S_FXW;
                S_FXW: begin
                    if (w_div_done) begin
                        r_fx    <= w_frac;
                        r_state <= S_AR1;
                    end
                end
                S_AR1: r_state <= S_AR2;
                S_AR2: r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_out_free) begin
                        r_mv    <= 1'b1;
                        r_mdata <= {4'b0, r_e[C_POSW-1:0], r_d[C_POSW-1:0], w_value};
                        r_mlast <= (r_d + C_SZW'(1) == r_d1) && (r_e + C_SZW'(1) == r_e1);
                        r_muser <= (r_d == w_dw - C_SZW'(1)) && (r_e == w_dh - C_SZW'(1));
                        if (r_d + C_SZW'(1) != r_d1) begin
                            r_d     <= r_d + C_SZW'(1);
                            r_state <= S_FXS;
                        end else if (r_e + C_SZW'(1) != r_e1) begin
                            r_e     <= r_e + C_SZW'(1);
                            r_state <= S_FYS;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_lu   <= r_up;
                    r_ll   <= r_p;
                    if ((C_SZW+1)'(r_c) + (C_SZW+1)'(1) >= (C_SZW+1)'(w_sw)) begin
                        r_scol <= '0;
                        r_pcol <= '0;
                        if ((C_SZW+1)'(r_r) + (C_SZW+1)'(1) >= (C_SZW+1)'(w_sh)) begin
                            r_srow <= '0;
                            r_prow <= '0;
                        end else begin
                            r_srow <= r_r + RW'(1);
                            r_prow <= r_e1;
                        end
                    end else begin
                        r_scol <= r_c + CW'(1);
                        r_srow <= r_r;
                        r_pcol <= r_d1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mv;
    assign m_tdata  = r_mdata;
    assign m_tlast  = r_mlast;
    assign m_tuser  = r_muser;

`include "bilinear_image_scaler_assert.svh"

    `BIS_ASSERT_NOW(a_frame_end_is_last, m_tvalid && m_tuser, m_tlast, "frame end without last")
    `BIS_ASSERT_NOW(a_div_done_waited,
        w_div_done,
        (r_state == S_CWAIT) || (r_state == S_RWAIT) || (r_state == S_FYW) || (r_state == S_FXW),
        "divider result with nobody waiting")
    `BIS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

@@ test/bilinear_image_scaler_tb.sv @@
// self-checking testbench for bilinear_image_scaler: streams grey frames, predicts every
// destination pixel with its own fixed-point bilinear model and checks each output beat
// depends on bis_pkg and the bilinear_image_scaler rtl
module bilinear_image_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bis_pkg::*;

    typedef struct {
        logic [7:0]  pix;
        logic [13:0] col;
        logic [13:0] row;
        logic        last;
        logic        fdone;
    } t_dst_pix;

    localparam int unsigned ONE = 256;
    localparam int DRAIN_CYCLES = 2500;
    localparam int WATCHDOG_LIMIT = 60000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [C_OUT_TDATAW-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic i_cfg_we = 1'b0;
    logic [C_CFG_IDXW-1:0] i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;

    logic [7:0] src_pixels[$];
    t_dst_pix dst_expected[$];
    int errors = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // predictor state
    logic [7:0] line_mem[4096];
    int unsigned reg_sw = 1, reg_sh = 1, reg_dw = 1, reg_dh = 1;
    int unsigned left_up = 0, left_low = 0, cur_col = 0, cur_row = 0;
    int unsigned next_dcol = 0, next_drow = 0;

    bilinear_image_scaler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_src(int unsigned v);
        if (v < 1) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic int unsigned clamp_dst(int unsigned v, int unsigned s);
        int unsigned lim;
        lim = s * 4;
        if (lim > 16384) lim = 16384;
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // lower-right source tap and its weight for destination index d
    function automatic void src_tap(int unsigned d, int unsigned s, int unsigned n,
                                    output int unsigned tap, output int unsigned frac);
        longint num, den, i, rem, f;
        num = (2 * longint'(d) + 1) * longint'(s) - longint'(n);
        tap = 0;
        frac = 0;
        if (num > 0) begin
            den = 2 * longint'(n);
            i = num / den;
            rem = num % den;
            if (i >= longint'(s) - 1) begin
                tap = s - 1;
            end else begin
                f = (rem * ONE) / den;
                if (f == 0) begin
                    tap = int'(i);
                end else begin
                    tap = int'(i) + 1;
                    frac = int'(f);
                end
            end
        end
    endfunction

    function automatic void restart_frame();
        left_up = 0; left_low = 0; cur_col = 0; cur_row = 0;
        next_dcol = 0; next_drow = 0;
    endfunction

    // work out all destination pixels completed by one source pixel
    function automatic void scale_pixel(logic [7:0] p);
        int unsigned sw, sh, dw, dh, c, r, up, d1, e1, tap, fx, fy, n;
        longint unsigned tl, tr, bl, top, bot, sum, val;
        t_dst_pix run[$];
        t_dst_pix px;
        sw = clamp_src(reg_sw); sh = clamp_src(reg_sh);
        dw = clamp_dst(reg_dw, sw); dh = clamp_dst(reg_dh, sh);
        c = (cur_col >= sw) ? 0 : cur_col;
        r = (cur_row >= sh) ? 0 : cur_row;
        up = line_mem[c];
        d1 = next_dcol;
        while (d1 < dw) begin
            src_tap(d1, sw, dw, tap, fx);
            if (tap != c) break;
            d1++;
        end
        e1 = next_drow;
        while (e1 < dh) begin
            src_tap(e1, sh, dh, tap, fy);
            if (tap != r) break;
            e1++;
        end
        n = 0;
        for (int unsigned e = next_drow; e < e1; e++) begin
            src_tap(e, sh, dh, tap, fy);
            for (int unsigned d = next_dcol; d < d1 && n < 64; d++) begin
                src_tap(d, sw, dw, tap, fx);
                bl = fx ? left_low : p;
                tr = fy ? up : p;
                tl = fy ? (fx ? left_up : up) : bl;
                top = (ONE - fx) * tl + fx * tr;
                bot = (ONE - fx) * bl + fx * p;
                sum = top * (ONE - fy) + bot * fy;
                val = (sum + 32768) >> 16;
                if (val > 255) val = 255;
                px.pix = val[7:0];
                px.col = d[13:0];
                px.row = e[13:0];
                px.last = 1'b0;
                px.fdone = (d == dw - 1 && e == dh - 1);
                run.push_back(px);
                n++;
            end
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[k]) dst_expected.push_back(run[k]);
        left_up = up;
        left_low = p;
        line_mem[c] = p;
        next_dcol = d1;
        if (c + 1 >= sw) begin
            cur_col = 0;
            next_dcol = 0;
            next_drow = e1;
            if (r + 1 >= sh) begin
                cur_row = 0;
                next_drow = 0;
            end else begin
                cur_row = r + 1;
            end
        end else begin
            cur_col = c + 1;
            cur_row = r;
        end
    endfunction

    // source pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) scale_pixel(s_tdata);
            if (src_pixels.size() > 0 && $urandom_range(99) >= gap_pct) begin
                s_tdata <= src_pixels.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor, backpressure and watchdog
    always @(posedge i_clk) begin
        t_dst_pix want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[bilinear_image_scaler] ERROR");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (dst_expected.size() == 0) begin
                    $error("unexpected beat col=%0d row=%0d", m_tdata[21:8], m_tdata[35:22]);
                    errors++;
                end else begin
                    want = dst_expected.pop_front();
                    if (m_tdata[7:0] !== want.pix) begin
                        $error("out_pixel exp %0d got %0d", want.pix, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[21:8] !== want.col) begin
                        $error("out_col exp %0d got %0d", want.col, m_tdata[21:8]);
                        errors++;
                    end
                    if (m_tdata[35:22] !== want.row) begin
                        $error("out_row exp %0d got %0d", want.row, m_tdata[35:22]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run exp %0d got %0d", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.fdone) begin
                        $error("frame_done exp %0d got %0d", want.fdone, m_tuser);
                        errors++;
                    end
                end
            end
            // one long hold-off while source pixels are still queued, so the block
            // backs up into its input
            if (!hold_done && results_seen >= 200 && src_pixels.size() > 4) begin
                hold_done <= 1'b1;
                hold_left <= 1500;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (src_pixels.size() > 0 || s_tvalid || dst_expected.size() > 0);
        // downscaled tails give no beats, so let any leftover work finish
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[14:0];
        case (idx)
            CFG_SRC_WIDTH:  reg_sw = v & 16'h1FFF;
            CFG_SRC_HEIGHT: reg_sh = v & 16'h1FFF;
            CFG_DST_WIDTH:  reg_dw = v & 16'h7FFF;
            default:        reg_dh = v & 16'h7FFF;
        endcase
        restart_frame();
    endtask

    // set up a new size and queue num_px pixels (0 means one whole frame)
    task automatic run_frame(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, int num_px, bit extremes);
        int total;
        wait_idle();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        total = (num_px > 0) ? num_px : clamp_src(sw & 16'h1FFF) * clamp_src(sh & 16'h1FFF);
        for (int k = 0; k < total; k++) begin
            if (extremes) src_pixels.push_back((k % 2) ? 8'hFF : 8'h00);
            else src_pixels.push_back($urandom_range(255));
        end
    endtask

    initial begin
        int sent;
        int unsigned sw, sh;
        foreach (line_mem[k]) line_mem[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 28;
        stall_pct = 66;

        // directed: max upscale, alternating bit patterns
        run_frame(2, 2, 8, 8, 0, 1'b0);
        src_pixels[0] = 8'h00; src_pixels[1] = 8'hFF;
        src_pixels[2] = 8'hAA; src_pixels[3] = 8'h55;
        run_frame(3, 3, 2, 2, 0, 1'b1);               // downscale with a silent tail
        run_frame(0, 0, 0, 0, 2, 1'b1);               // zero sizes act as one
        run_frame(8191, 1, 32767, 0, 6, 1'b1);        // oversized registers clamp
        run_frame(4, 1, 16384, 4, 4, 1'b1);           // destination above 4x

        sent = 0;
        while (sent < 395) begin
            if (sent < 140) begin
                gap_pct = 28; stall_pct = 66;
            end else if (sent < 280) begin
                gap_pct = 66; stall_pct = 28;
            end else begin
                gap_pct = 0; stall_pct = 0;
            end
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 6);
            run_frame(($urandom_range(15) == 0) ? 0 : sw, sh,
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4 * sw + 3),
                      $urandom_range(1, 4 * sh + 3), 0, $urandom_range(7) == 0);
            sent += src_pixels.size();
        end

        wait_idle();
        if (errors == 0) begin
            $display("[bilinear_image_scaler] OK");
        end else begin
            $display("[bilinear_image_scaler] ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_coord_div.sv
rtl/bis_interp.sv
rtl/bilinear_image_scaler.sv
test/bilinear_image_scaler_tb.sv
